// ===== design/rgbhsv_pkg.sv =====
`default_nettype none
package rgbhsv_pkg;

  localparam int unsigned CompW = 16;
  // Top quotient bit index for the restoring dividers (quotients are QuotW+1 bits).
  localparam int unsigned QuotW = 16;

  typedef logic [CompW-1:0] comp_t;

  // One slot of the divider chain: two independent divisions in flight.
  typedef struct packed {
    logic        vld;
    logic        gray;
    comp_t       bright;
    logic [49:0] sat_rem;
    logic [49:0] sat_div;
    logic [QuotW:0] sat_quo;
    logic [53:0] hue_rem;
    logic [53:0] hue_div;
    logic [QuotW:0] hue_quo;
  } slot_t;

endpackage
`default_nettype wire

// ===== design/rgbhsv_if.sv =====
`default_nettype none
interface rgbhsv_in_if;
  import rgbhsv_pkg::*;
  logic  valid;
  logic  ready;
  comp_t red;
  comp_t green;
  comp_t blue;
  modport source (output valid, red, green, blue, input ready);
  modport sink (input valid, red, green, blue, output ready);
endinterface

interface rgbhsv_out_if;
  import rgbhsv_pkg::*;
  logic  valid;
  logic  ready;
  comp_t hue;
  comp_t saturation;
  comp_t brightness;
  modport source (output valid, hue, saturation, brightness, input ready);
  modport sink (input valid, hue, saturation, brightness, output ready);
endinterface
`default_nettype wire

// ===== design/rgbhsv_cell.sv =====
`default_nettype none
// One quotient bit of both divisions per cell (restoring, shift-subtract).
module rgbhsv_cell
  import rgbhsv_pkg::*;
#(
  parameter int unsigned Bit = 0
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire slot_t slot_i,
  output slot_t      slot_o
);

  slot_t slot_d, slot_q;
  logic [49:0] sat_try;
  logic [53:0] hue_try;

  always_comb begin
    slot_d = slot_i;
    sat_try = slot_i.sat_div << Bit;
    hue_try = slot_i.hue_div << Bit;
    if (slot_i.sat_rem >= sat_try) begin
      slot_d.sat_rem = slot_i.sat_rem - sat_try;
      slot_d.sat_quo[Bit] = 1'b1;
    end
    if (slot_i.hue_rem >= hue_try) begin
      slot_d.hue_rem = slot_i.hue_rem - hue_try;
      slot_d.hue_quo[Bit] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (en_i) begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule
`default_nettype wire

// ===== design/rgbhsv_front.sv =====
`default_nettype none
// Max/min/sector pick, then the numerators.
module rgbhsv_front
  import rgbhsv_pkg::*;
#(
  parameter int unsigned ComponentMax = 65535
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  en_i,
  input  wire logic  vld_i,
  input  wire comp_t red_i,
  input  wire comp_t green_i,
  input  wire comp_t blue_i,
  output slot_t      slot_o
);

  localparam logic [16:0] Cmax = 17'(ComponentMax);

  comp_t hi, lo, delta, plus, minus;
  logic [2:0] base;
  logic [19:0] num;   // base*delta + plus - minus, <= 6*delta
  logic s0_vld_q;
  comp_t hi_q, delta_q;
  logic [19:0] num_q;
  slot_t slot_d, slot_q;

  always_comb begin
    hi = (red_i > green_i) ? red_i : green_i;
    hi = (hi > blue_i) ? hi : blue_i;
    lo = (red_i < green_i) ? red_i : green_i;
    lo = (lo < blue_i) ? lo : blue_i;
    delta = hi - lo;
    if (red_i == hi) begin
      base = 3'd1; plus = green_i; minus = blue_i;
    end else if (green_i == hi) begin
      base = 3'd3; plus = blue_i; minus = red_i;
    end else begin
      base = 3'd5; plus = red_i; minus = green_i;
    end
    num = 20'(base) * 20'(delta) + 20'(plus) - 20'(minus);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
    end else if (en_i) begin
      s0_vld_q <= vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      hi_q    <= hi;
      delta_q <= delta;
      num_q   <= num;
    end
  end

  // sat = (2*delta*C + hi) / (2*hi); hue = (2*num*C + 6*delta) / (12*delta)
  always_comb begin
    slot_d = '0;
    slot_d.vld     = s0_vld_q;
    slot_d.gray    = (delta_q == '0);
    slot_d.bright  = hi_q;
    slot_d.sat_rem = 50'({delta_q, 1'b0}) * 50'(Cmax) + 50'(hi_q);
    slot_d.sat_div = 50'({hi_q, 1'b0});
    slot_d.hue_rem = 54'({num_q, 1'b0}) * 54'(Cmax) + 54'(delta_q) * 54'd6;
    slot_d.hue_div = 54'(delta_q) * 54'd12;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else if (en_i) begin
      slot_q <= slot_d;
    end
  end

  assign slot_o = slot_q;

endmodule
`default_nettype wire

// ===== design/rgb_to_hsv_converter.sv =====
`default_nettype none
// RGB to HSV pixel converter.
// in_if (sink): red/green/blue, 16 bits each, accepted when valid && ready.
// out_if (source): hue/saturation/brightness, one item per input item.
// Throughput: one item per cycle, sustained while out.ready stays high.
// Pipeline: 20 register stages: 2 front stages, 17 divider cells, 1 output
//   register; the first front stage captures at the accepting edge.
// Front: max/min/sector select, then the two numerators.
// Divider: a chain of 17 identical cells; cell k resolves quotient bit 16-k of
//   both the saturation and the hue division (restoring, MSB first).
// Output: gray override, min-1 saturation, hue clamp to COMPONENT_MAX.
// Stall: the whole chain advances together; when the output register holds
//   an item the receiver has not taken, the chain freezes and in.ready drops.
//   in.ready stays high whenever the output slot is empty or being taken,
//   so an item can enter while a finished result is being taken.
// Reset: clears all valid bits; no item is in flight afterwards.
module rgb_to_hsv_converter
  import rgbhsv_pkg::*;
#(
  parameter int unsigned COMPONENT_MAX = 65535
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  rgbhsv_in_if.sink   in_if,
  rgbhsv_out_if.source out_if
);

  localparam int unsigned NumCells = QuotW + 1;
  localparam logic [QuotW:0] Cmax = (QuotW+1)'(COMPONENT_MAX);

  logic  en;
  slot_t chain [NumCells+1];
  logic  out_vld_q;
  comp_t hue_q, sat_q, bright_q;
  slot_t last;
  logic [QuotW:0] sat_fix, hue_fix;

  // Chain advances whenever the output register is free or being drained.
  assign en = !out_vld_q || out_if.ready;
  assign in_if.ready = en;

  rgbhsv_front #(.ComponentMax(COMPONENT_MAX)) u_front (
    .clk_i, .rst_ni, .en_i(en), .vld_i(in_if.valid),
    .red_i(in_if.red), .green_i(in_if.green), .blue_i(in_if.blue),
    .slot_o(chain[0])
  );

  // Cells run from the top quotient bit down.
  for (genvar i = 0; i < NumCells; i++) begin : g_cell
    rgbhsv_cell #(.Bit(NumCells-1-i)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .slot_i(chain[i]), .slot_o(chain[i+1])
    );
  end

  assign last = chain[NumCells];

  always_comb begin
    sat_fix = (last.sat_quo == '0) ? (QuotW+1)'(1) : last.sat_quo;
    hue_fix = (last.hue_quo > Cmax) ? Cmax : last.hue_quo;
    if (last.gray) begin
      sat_fix = '0;
      hue_fix = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= last.vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      hue_q    <= hue_fix[CompW-1:0];
      sat_q    <= sat_fix[CompW-1:0];
      bright_q <= last.bright;
    end
  end

  assign out_if.valid      = out_vld_q;
  assign out_if.hue        = hue_q;
  assign out_if.saturation = sat_q;
  assign out_if.brightness = bright_q;

endmodule
`default_nettype wire
